// ===== design/kvi_pkg.sv =====
// Shared types, constants and the fixed normal table for the keyframe vertex interpolator.
package kvi_pkg;

  localparam int unsigned KVI_NORMAL_COUNT = 162;
  localparam int unsigned NRM_TABLE_LEN    = 162;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_OUT_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_OUT_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_U_OFFSET    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_V_OFFSET    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_U_GAIN      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_V_GAIN      = 3'd6;

  // element 0 is x, 1 is y, 2 is z; each Q1.14
  typedef logic [0:2][15:0] nrm_vec_t;

  localparam logic signed [15:0] N0   = 16'sd0;
  localparam logic signed [15:0] N100 = 16'sd16384;
  localparam logic signed [15:0] N525 = 16'sd8614;
  localparam logic signed [15:0] N850 = 16'sd13937;
  localparam logic signed [15:0] N442 = 16'sd7256;
  localparam logic signed [15:0] N238 = 16'sd3913;
  localparam logic signed [15:0] N864 = 16'sd14159;
  localparam logic signed [15:0] N295 = 16'sd4837;
  localparam logic signed [15:0] N955 = 16'sd15654;
  localparam logic signed [15:0] N309 = 16'sd5063;
  localparam logic signed [15:0] N500 = 16'sd8192;
  localparam logic signed [15:0] N809 = 16'sd13255;
  localparam logic signed [15:0] N162 = 16'sd2662;
  localparam logic signed [15:0] N262 = 16'sd4307;
  localparam logic signed [15:0] N951 = 16'sd15582;
  localparam logic signed [15:0] N147 = 16'sd2419;
  localparam logic signed [15:0] N716 = 16'sd11740;
  localparam logic signed [15:0] N681 = 16'sd11169;
  localparam logic signed [15:0] N587 = 16'sd9630;
  localparam logic signed [15:0] N425 = 16'sd6969;
  localparam logic signed [15:0] N688 = 16'sd11275;

  localparam nrm_vec_t NRM_TABLE [NRM_TABLE_LEN] = '{
    '{-N525,N0,N850},'{-N442,N238,N864},'{-N295,N0,N955},'{-N309,N500,N809},
    '{-N162,N262,N951},'{N0,N0,N100},'{N0,N850,N525},'{-N147,N716,N681},
    '{N147,N716,N681},'{N0,N525,N850},'{N309,N500,N809},'{N525,N0,N850},
    '{N295,N0,N955},'{N442,N238,N864},'{N162,N262,N951},'{-N681,N147,N716},
    '{-N809,N309,N500},'{-N587,N425,N688},'{-N850,N525,N0},'{-N864,N442,N238},
    '{-N716,N681,N147},'{-N688,N587,N425},'{-N500,N809,N309},'{-N238,N864,N442},
    '{-N425,N688,N587},'{-N716,N681,-N147},'{-N500,N809,-N309},'{-N525,N850,N0},
    '{N0,N850,-N525},'{-N238,N864,-N442},'{N0,N955,-N295},'{-N262,N951,-N162},
    '{N0,N100,N0},'{N0,N955,N295},'{-N262,N951,N162},'{N238,N864,N442},
    '{N262,N951,N162},'{N500,N809,N309},'{N238,N864,-N442},'{N262,N951,-N162},
    '{N500,N809,-N309},'{N850,N525,N0},'{N716,N681,N147},'{N716,N681,-N147},
    '{N525,N850,N0},'{N425,N688,N587},'{N864,N442,N238},'{N688,N587,N425},
    '{N809,N309,N500},'{N681,N147,N716},'{N587,N425,N688},'{N955,N295,N0},
    '{N100,N0,N0},'{N951,N162,N262},'{N850,-N525,N0},'{N955,-N295,N0},
    '{N864,-N442,N238},'{N951,-N162,N262},'{N809,-N309,N500},'{N681,-N147,N716},
    '{N850,N0,N525},'{N864,N442,-N238},'{N809,N309,-N500},'{N951,N162,-N262},
    '{N525,N0,-N850},'{N681,N147,-N716},'{N681,-N147,-N716},'{N850,N0,-N525},
    '{N809,-N309,-N500},'{N864,-N442,-N238},'{N951,-N162,-N262},'{N147,N716,-N681},
    '{N309,N500,-N809},'{N425,N688,-N587},'{N442,N238,-N864},'{N587,N425,-N688},
    '{N688,N587,-N425},'{-N147,N716,-N681},'{-N309,N500,-N809},'{N0,N525,-N850},
    '{-N525,N0,-N850},'{-N442,N238,-N864},'{-N295,N0,-N955},'{-N162,N262,-N951},
    '{N0,N0,-N100},'{N295,N0,-N955},'{N162,N262,-N951},'{-N442,-N238,-N864},
    '{-N309,-N500,-N809},'{-N162,-N262,-N951},'{N0,-N850,-N525},'{-N147,-N716,-N681},
    '{N147,-N716,-N681},'{N0,-N525,-N850},'{N309,-N500,-N809},'{N442,-N238,-N864},
    '{N162,-N262,-N951},'{N238,-N864,-N442},'{N500,-N809,-N309},'{N425,-N688,-N587},
    '{N716,-N681,-N147},'{N688,-N587,-N425},'{N587,-N425,-N688},'{N0,-N955,-N295},
    '{N0,-N100,N0},'{N262,-N951,-N162},'{N0,-N850,N525},'{N0,-N955,N295},
    '{N238,-N864,N442},'{N262,-N951,N162},'{N500,-N809,N309},'{N716,-N681,N147},
    '{N525,-N850,N0},'{-N238,-N864,-N442},'{-N500,-N809,-N309},'{-N262,-N951,-N162},
    '{-N850,-N525,N0},'{-N716,-N681,-N147},'{-N716,-N681,N147},'{-N525,-N850,N0},
    '{-N500,-N809,N309},'{-N238,-N864,N442},'{-N262,-N951,N162},'{-N864,-N442,N238},
    '{-N809,-N309,N500},'{-N688,-N587,N425},'{-N681,-N147,N716},'{-N442,-N238,N864},
    '{-N587,-N425,N688},'{-N309,-N500,N809},'{-N147,-N716,N681},'{-N425,-N688,N587},
    '{-N162,-N262,N951},'{N442,-N238,N864},'{N162,-N262,N951},'{N309,-N500,N809},
    '{N147,-N716,N681},'{N0,-N525,N850},'{N425,-N688,N587},'{N587,-N425,N688},
    '{N688,-N587,N425},'{-N955,N295,N0},'{-N951,N162,N262},'{-N100,N0,N0},
    '{-N850,N0,N525},'{-N955,-N295,N0},'{-N951,-N162,N262},'{-N809,N309,-N500},
    '{-N587,N425,-N688},'{-N681,N147,-N716},'{-N864,N442,-N238},'{-N951,N162,-N262},
    '{-N850,N0,-N525},'{-N681,-N147,-N716},'{-N809,-N309,-N500},'{-N864,-N442,-N238},
    '{-N951,-N162,-N262},'{-N688,N587,-N425},'{-N425,N688,-N587},'{-N425,-N688,-N587},
    '{-N587,-N425,-N688},'{-N688,-N587,-N425}
  };

  // entries past the standard set read as zero vectors
  function automatic nrm_vec_t nrm_fetch(logic [7:0] idx);
    nrm_vec_t v;
    v = '0;
    if (int'(idx) < int'(NRM_TABLE_LEN)) begin
      v = NRM_TABLE[idx];
    end
    return v;
  endfunction

endpackage

// ===== design/kvi_nrm_rom.sv =====
// Two-port synchronous normal table ROM with index clamping.
module kvi_nrm_rom import kvi_pkg::*; #(
  parameter int unsigned NORMAL_COUNT = KVI_NORMAL_COUNT
) (
  input  logic       clk_i,
  input  logic [7:0] idx_a_i,
  input  logic [7:0] idx_b_i,
  output nrm_vec_t   rd_a_o,
  output nrm_vec_t   rd_b_o
);

  logic [7:0] addr_a;
  logic [7:0] addr_b;
  nrm_vec_t   rd_a_q;
  nrm_vec_t   rd_b_q;

  // out-of-range index reads the last entry
  assign addr_a = ({1'b0, idx_a_i} >= 9'(NORMAL_COUNT)) ? 8'(NORMAL_COUNT - 1) : idx_a_i;
  assign addr_b = ({1'b0, idx_b_i} >= 9'(NORMAL_COUNT)) ? 8'(NORMAL_COUNT - 1) : idx_b_i;

  always_ff @(posedge clk_i) begin
    rd_a_q <= nrm_fetch(addr_a);
    rd_b_q <= nrm_fetch(addr_b);
  end

  assign rd_a_o = rd_a_q;
  assign rd_b_o = rd_b_q;

endmodule

// ===== design/kvi_nrm_blend.sv =====
// Four-stage blend of two table normals by the blend factor.
module kvi_nrm_blend import kvi_pkg::*; (
  input  logic        clk_i,
  input  nrm_vec_t    na_i,
  input  nrm_vec_t    nb_i,
  input  logic [16:0] t_i,
  output nrm_vec_t    n_o
);

  logic [2:0][16:0]   dn;
  logic [2:0][34:0]   sum3;
  nrm_vec_t           na2_q;
  logic signed [34:0] prod2_q [3];
  nrm_vec_t           n3_q;
  nrm_vec_t           n4_q;
  nrm_vec_t           n5_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dn[k]   = {nb_i[k][15], nb_i[k]} - {na_i[k][15], na_i[k]};
      // na*2^16 + t*dn, plus half an lsb, then floor by 2^16
      sum3[k] = {{3{na2_q[k][15]}}, na2_q[k], 16'h0} + prod2_q[k] + 35'h8000;
    end
  end

  always_ff @(posedge clk_i) begin
    na2_q <= na_i;
    for (int k = 0; k < 3; k++) begin
      prod2_q[k] <= $signed({1'b0, t_i}) * $signed(dn[k]);
      n3_q[k]    <= sum3[k][31:16];
    end
    n4_q <= n3_q;
    n5_q <= n4_q;
  end

  assign n_o = n5_q;

endmodule

// ===== design/kvi_pos_lane.sv =====
// One position axis: blend, scale by Q8.8 gain in split partial products, round, saturate.
module kvi_pos_lane (
  input  logic        clk_i,
  input  logic [23:0] a_i,
  input  logic [23:0] b_i,
  input  logic [16:0] t_i,
  input  logic [15:0] gain_i,
  output logic [23:0] res_o
);

  logic signed [24:0] diff;
  logic [42:0]        mix_full;
  logic [57:0]        sum5;
  logic [33:0]        shf5;

  logic [23:0]        a2_q;
  logic signed [42:0] prod2_q;
  logic [39:0]        mix3_q;
  logic signed [40:0] hi4_q;
  logic [31:0]        lo4_q;
  logic [23:0]        res5_q;

  assign diff     = $signed({b_i[23], b_i}) - $signed({a_i[23], a_i});
  // blended value stays between a and b, so 40 bits hold it
  assign mix_full = {{3{a2_q[23]}}, a2_q, 16'h0} + prod2_q;
  assign sum5     = {hi4_q[40], hi4_q, 16'h0} + {26'h0, lo4_q} + 58'h800000;
  assign shf5     = sum5[57:24];

  always_ff @(posedge clk_i) begin
    a2_q    <= a_i;
    prod2_q <= $signed({1'b0, t_i}) * diff;
    mix3_q  <= mix_full[39:0];
    hi4_q   <= $signed(mix3_q[39:16]) * $signed({1'b0, gain_i});
    lo4_q   <= mix3_q[15:0] * gain_i;
    if (shf5[33:23] == {11{shf5[23]}}) begin
      res5_q <= shf5[23:0];
    end else if (shf5[33]) begin
      res5_q <= 24'h800000;
    end else begin
      res5_q <= 24'h7FFFFF;
    end
  end

  assign res_o = res5_q;

endmodule

// ===== design/keyframe_vertex_interpolator.sv =====
// Keyframe vertex interpolator top level: config registers, pipeline control, texture mapping.
//
// Usage:
//   Requests: drive the vertex fields and raise start; a request is taken at
//   every rising edge with start high and busy low. busy stays low, so one
//   vertex can be issued on every clock.
//   Results: each request yields one result, shown on the output ports for one
//   cycle with done_o high. Results come out in request order. The receiver
//   cannot hold them off; a result not captured in its cycle is gone.
//   Throughput: one vertex per clock. The five-stage pipeline is set by the
//   synchronous normal ROM read and the split Q8.8 gain multiply.
//   Configuration: cfg_we_i, cfg_idx_i and cfg_wdata_i write one register per
//   edge; write only while no request is in flight. Unknown indices are ignored.
//   Reset: rst_ni clears the in-flight marks and loads the gains with 1.0 and
//   the texture offsets with zero. The normal table is a fixed ROM.
module keyframe_vertex_interpolator import kvi_pkg::*; #(
  parameter int unsigned NORMAL_COUNT = KVI_NORMAL_COUNT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  output logic                  done_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic [23:0]           pos_a_x_i,
  input  logic [23:0]           pos_a_y_i,
  input  logic [23:0]           pos_a_z_i,
  input  logic [23:0]           pos_b_x_i,
  input  logic [23:0]           pos_b_y_i,
  input  logic [23:0]           pos_b_z_i,
  input  logic [7:0]            normal_a_index_i,
  input  logic [7:0]            normal_b_index_i,
  input  logic [16:0]           tex_s_i,
  input  logic [16:0]           tex_t_i,
  input  logic [16:0]           blend_i,
  input  logic                  last_vertex_i,
  output logic [23:0]           out_x_o,
  output logic [23:0]           out_y_o,
  output logic [23:0]           out_z_o,
  output logic [15:0]           normal_x_o,
  output logic [15:0]           normal_y_o,
  output logic [15:0]           normal_z_o,
  output logic [19:0]           out_s_o,
  output logic [19:0]           out_t_o,
  output logic                  last_out_o
);

  logic        accept;
  logic [16:0] blend_c;

  logic [15:0] scale_x_q;
  logic [15:0] scale_y_q;
  logic [15:0] scale_z_q;
  logic [16:0] u_off_q;
  logic [16:0] v_off_q;
  logic [15:0] u_gain_q;
  logic [15:0] v_gain_q;

  logic [5:1]  vld_q;
  logic [5:1]  last_q;

  logic [2:0][23:0] pa1_q;
  logic [2:0][23:0] pb1_q;
  logic [2:0][15:0] gain;
  logic [2:0][23:0] pos_res;
  logic [16:0]      t1_q;
  logic [16:0]      tex_s1_q;
  logic [16:0]      tex_t1_q;

  nrm_vec_t    na1;
  nrm_vec_t    nb1;
  nrm_vec_t    n5;

  logic [32:0] sp2_q;
  logic [32:0] tp2_q;
  logic [33:0] s_sum;
  logic [25:0] s_shf;
  logic [35:0] t_sum;
  logic [27:0] t_shf;
  logic [19:0] s3_d;
  logic [19:0] t3_d;
  logic [19:0] s3_q;
  logic [19:0] t3_q;
  logic [19:0] s4_q;
  logic [19:0] t4_q;
  logic [19:0] s5_q;
  logic [19:0] t5_q;

  // fully pipelined, a request is taken every cycle
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign blend_c = (blend_i > 17'd65536) ? 17'd65536 : blend_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_x_q <= 16'd256;
      scale_y_q <= 16'd256;
      scale_z_q <= 16'd256;
      u_off_q   <= '0;
      v_off_q   <= '0;
      u_gain_q  <= 16'd256;
      v_gain_q  <= 16'd256;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SCALE_X:     scale_x_q <= cfg_wdata_i[15:0];
        CFG_SCALE_OUT_Y: scale_y_q <= cfg_wdata_i[15:0];
        CFG_SCALE_OUT_Z: scale_z_q <= cfg_wdata_i[15:0];
        CFG_U_OFFSET:    u_off_q   <= cfg_wdata_i;
        CFG_V_OFFSET:    v_off_q   <= cfg_wdata_i;
        CFG_U_GAIN:      u_gain_q  <= cfg_wdata_i[15:0];
        CFG_V_GAIN:      v_gain_q  <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[4:1], accept};
    end
  end

  always_ff @(posedge clk_i) begin
    last_q   <= {last_q[4:1], last_vertex_i};
    pa1_q    <= {pos_a_z_i, pos_a_y_i, pos_a_x_i};
    pb1_q    <= {pos_b_z_i, pos_b_y_i, pos_b_x_i};
    t1_q     <= blend_c;
    tex_s1_q <= tex_s_i;
    tex_t1_q <= tex_t_i;
  end

  assign gain = {scale_z_q, scale_y_q, scale_x_q};

  for (genvar g = 0; g < 3; g++) begin : g_pos
    kvi_pos_lane u_lane (
      .clk_i  (clk_i),
      .a_i    (pa1_q[g]),
      .b_i    (pb1_q[g]),
      .t_i    (t1_q),
      .gain_i (gain[g]),
      .res_o  (pos_res[g])
    );
  end

  kvi_nrm_rom #(
    .NORMAL_COUNT (NORMAL_COUNT)
  ) u_rom (
    .clk_i   (clk_i),
    .idx_a_i (normal_a_index_i),
    .idx_b_i (normal_b_index_i),
    .rd_a_o  (na1),
    .rd_b_o  (nb1)
  );

  kvi_nrm_blend u_blend (
    .clk_i (clk_i),
    .na_i  (na1),
    .nb_i  (nb1),
    .t_i   (t1_q),
    .n_o   (n5)
  );

  // texture: u = off + s*gain; v = 1.0 - (off + t*gain); Q8.8 gains, round by 2^8
  always_comb begin
    s_sum = {9'h0, u_off_q, 8'h0} + {1'b0, sp2_q} + 34'd128;
    s_shf = s_sum[33:8];
    s3_d  = (|s_shf[25:19]) ? 20'h7FFFF : s_shf[19:0];
    t_sum = 36'h1000000 - {11'h0, v_off_q, 8'h0} - {3'h0, tp2_q} + 36'd128;
    t_shf = t_sum[35:8];
    if (t_shf[27:19] == {9{t_shf[19]}}) begin
      t3_d = t_shf[19:0];
    end else if (t_shf[27]) begin
      t3_d = 20'h80000;
    end else begin
      t3_d = 20'h7FFFF;
    end
  end

  always_ff @(posedge clk_i) begin
    sp2_q <= tex_s1_q * u_gain_q;
    tp2_q <= tex_t1_q * v_gain_q;
    s3_q  <= s3_d;
    t3_q  <= t3_d;
    s4_q  <= s3_q;
    t4_q  <= t3_q;
    s5_q  <= s4_q;
    t5_q  <= t4_q;
  end

  assign done_o     = vld_q[5];
  assign last_out_o = last_q[5];
  assign out_x_o    = pos_res[0];
  assign out_y_o    = pos_res[1];
  assign out_z_o    = pos_res[2];
  assign normal_x_o = n5[0];
  assign normal_y_o = n5[1];
  assign normal_z_o = n5[2];
  assign out_s_o    = s5_q;
  assign out_t_o    = t5_q;

  a_req_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##5 done_o)
    else $error("request did not produce a result after five edges");

  a_done_has_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 5))
    else $error("result without a matching request");

  a_last_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> last_out_o == $past(last_vertex_i, 5))
    else $error("last marker misaligned with its result");

  a_nrm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($signed(normal_x_o) >= -16'sd16384 && $signed(normal_x_o) <= 16'sd16384 &&
                $signed(normal_y_o) >= -16'sd16384 && $signed(normal_y_o) <= 16'sd16384 &&
                $signed(normal_z_o) >= -16'sd16384 && $signed(normal_z_o) <= 16'sd16384))
    else $error("blended normal component out of unit range");

  a_s_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !out_s_o[19])
    else $error("mapped S went negative");

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the keyframe vertex interpolator.
`timescale 1ns / 100ps

module tb;
  import kvi_pkg::*;

  localparam int NRM_COUNT   = 162;
  localparam int STALL_LIMIT = 200;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  localparam int K0 = 0, K100 = 16384, K525 = 8614, K850 = 13937, K442 = 7256;
  localparam int K238 = 3913, K864 = 14159, K295 = 4837, K955 = 15654, K309 = 5063;
  localparam int K500 = 8192, K809 = 13255, K162 = 2662, K262 = 4307, K951 = 15582;
  localparam int K147 = 2419, K716 = 11740, K681 = 11169, K587 = 9630, K425 = 6969;
  localparam int K688 = 11275;

  // standard unit normal set, Q1.14
  localparam int UNIT_NORMALS [162][3] = '{
    '{-K525,K0,K850},'{-K442,K238,K864},'{-K295,K0,K955},'{-K309,K500,K809},
    '{-K162,K262,K951},'{K0,K0,K100},'{K0,K850,K525},'{-K147,K716,K681},
    '{K147,K716,K681},'{K0,K525,K850},'{K309,K500,K809},'{K525,K0,K850},
    '{K295,K0,K955},'{K442,K238,K864},'{K162,K262,K951},'{-K681,K147,K716},
    '{-K809,K309,K500},'{-K587,K425,K688},'{-K850,K525,K0},'{-K864,K442,K238},
    '{-K716,K681,K147},'{-K688,K587,K425},'{-K500,K809,K309},'{-K238,K864,K442},
    '{-K425,K688,K587},'{-K716,K681,-K147},'{-K500,K809,-K309},'{-K525,K850,K0},
    '{K0,K850,-K525},'{-K238,K864,-K442},'{K0,K955,-K295},'{-K262,K951,-K162},
    '{K0,K100,K0},'{K0,K955,K295},'{-K262,K951,K162},'{K238,K864,K442},
    '{K262,K951,K162},'{K500,K809,K309},'{K238,K864,-K442},'{K262,K951,-K162},
    '{K500,K809,-K309},'{K850,K525,K0},'{K716,K681,K147},'{K716,K681,-K147},
    '{K525,K850,K0},'{K425,K688,K587},'{K864,K442,K238},'{K688,K587,K425},
    '{K809,K309,K500},'{K681,K147,K716},'{K587,K425,K688},'{K955,K295,K0},
    '{K100,K0,K0},'{K951,K162,K262},'{K850,-K525,K0},'{K955,-K295,K0},
    '{K864,-K442,K238},'{K951,-K162,K262},'{K809,-K309,K500},'{K681,-K147,K716},
    '{K850,K0,K525},'{K864,K442,-K238},'{K809,K309,-K500},'{K951,K162,-K262},
    '{K525,K0,-K850},'{K681,K147,-K716},'{K681,-K147,-K716},'{K850,K0,-K525},
    '{K809,-K309,-K500},'{K864,-K442,-K238},'{K951,-K162,-K262},'{K147,K716,-K681},
    '{K309,K500,-K809},'{K425,K688,-K587},'{K442,K238,-K864},'{K587,K425,-K688},
    '{K688,K587,-K425},'{-K147,K716,-K681},'{-K309,K500,-K809},'{K0,K525,-K850},
    '{-K525,K0,-K850},'{-K442,K238,-K864},'{-K295,K0,-K955},'{-K162,K262,-K951},
    '{K0,K0,-K100},'{K295,K0,-K955},'{K162,K262,-K951},'{-K442,-K238,-K864},
    '{-K309,-K500,-K809},'{-K162,-K262,-K951},'{K0,-K850,-K525},'{-K147,-K716,-K681},
    '{K147,-K716,-K681},'{K0,-K525,-K850},'{K309,-K500,-K809},'{K442,-K238,-K864},
    '{K162,-K262,-K951},'{K238,-K864,-K442},'{K500,-K809,-K309},'{K425,-K688,-K587},
    '{K716,-K681,-K147},'{K688,-K587,-K425},'{K587,-K425,-K688},'{K0,-K955,-K295},
    '{K0,-K100,K0},'{K262,-K951,-K162},'{K0,-K850,K525},'{K0,-K955,K295},
    '{K238,-K864,K442},'{K262,-K951,K162},'{K500,-K809,K309},'{K716,-K681,K147},
    '{K525,-K850,K0},'{-K238,-K864,-K442},'{-K500,-K809,-K309},'{-K262,-K951,-K162},
    '{-K850,-K525,K0},'{-K716,-K681,-K147},'{-K716,-K681,K147},'{-K525,-K850,K0},
    '{-K500,-K809,K309},'{-K238,-K864,K442},'{-K262,-K951,K162},'{-K864,-K442,K238},
    '{-K809,-K309,K500},'{-K688,-K587,K425},'{-K681,-K147,K716},'{-K442,-K238,K864},
    '{-K587,-K425,K688},'{-K309,-K500,K809},'{-K147,-K716,K681},'{-K425,-K688,K587},
    '{-K162,-K262,K951},'{K442,-K238,K864},'{K162,-K262,K951},'{K309,-K500,K809},
    '{K147,-K716,K681},'{K0,-K525,K850},'{K425,-K688,K587},'{K587,-K425,K688},
    '{K688,-K587,K425},'{-K955,K295,K0},'{-K951,K162,K262},'{-K100,K0,K0},
    '{-K850,K0,K525},'{-K955,-K295,K0},'{-K951,-K162,K262},'{-K809,K309,-K500},
    '{-K587,K425,-K688},'{-K681,K147,-K716},'{-K864,K442,-K238},'{-K951,K162,-K262},
    '{-K850,K0,-K525},'{-K681,-K147,-K716},'{-K809,-K309,-K500},'{-K864,-K442,-K238},
    '{-K951,-K162,-K262},'{-K688,K587,-K425},'{-K425,K688,-K587},'{-K425,-K688,-K587},
    '{-K587,-K425,-K688},'{-K688,-K587,-K425}
  };

  typedef struct {
    logic [23:0] ax, ay, az, bx, by, bz;
    logic [7:0]  na, nb;
    logic [16:0] s, t, blend;
    logic        last;
  } vertex_t;

  typedef struct {
    logic [23:0] x, y, z;
    logic [15:0] nx, ny, nz;
    logic [19:0] s, t;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [15:0] scale_x, scale_y, scale_z;
    logic [16:0] u_off, v_off;
    logic [15:0] u_gain, v_gain;
  } regs_t;

  localparam regs_t REGS_RESET = '{16'd256, 16'd256, 16'd256, 17'd0, 17'd0, 16'd256, 16'd256};

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  done_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic [23:0] pos_a_x_i = '0, pos_a_y_i = '0, pos_a_z_i = '0;
  logic [23:0] pos_b_x_i = '0, pos_b_y_i = '0, pos_b_z_i = '0;
  logic [7:0]  normal_a_index_i = '0, normal_b_index_i = '0;
  logic [16:0] tex_s_i = '0, tex_t_i = '0, blend_i = '0;
  logic        last_vertex_i = 1'b0;
  logic [23:0] out_x_o, out_y_o, out_z_o;
  logic [15:0] normal_x_o, normal_y_o, normal_z_o;
  logic [19:0] out_s_o, out_t_o;
  logic        last_out_o;

  regs_t   active_regs = REGS_RESET;
  result_t predicted_vertices [$];
  int      mismatches = 0;
  int      quiet_cycles = 0;
  bit      allow_gaps = 1'b1;

  always #5 clk_i = ~clk_i;

  keyframe_vertex_interpolator #(.NORMAL_COUNT(NRM_COUNT)) DUT (
    .clk_i, .rst_ni, .start, .busy, .done_o,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .pos_a_x_i, .pos_a_y_i, .pos_a_z_i, .pos_b_x_i, .pos_b_y_i, .pos_b_z_i,
    .normal_a_index_i, .normal_b_index_i, .tex_s_i, .tex_t_i, .blend_i, .last_vertex_i,
    .out_x_o, .out_y_o, .out_z_o, .normal_x_o, .normal_y_o, .normal_z_o,
    .out_s_o, .out_t_o, .last_out_o
  );

  // round to nearest (ties up), drop sh fraction bits
  function automatic longint round_q(longint v, int sh);
    return (v + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic logic [23:0] lerp_pos(logic [23:0] a_raw, logic [23:0] b_raw,
                                           longint f, logic [15:0] gain);
    longint a, b, g, r;
    a = $signed(a_raw);
    b = $signed(b_raw);
    g = gain;
    r = clip(round_q((a * 65536 + f * (b - a)) * g, 24), -8388608, 8388607);
    return r[23:0];
  endfunction

  function automatic result_t predict_vertex(vertex_t v);
    result_t     r;
    longint      f, na, nb, n, acc;
    int          ia, ib;
    logic [15:0] nrm [3];
    f = (v.blend > 17'd65536) ? 65536 : v.blend;
    r.x = lerp_pos(v.ax, v.bx, f, active_regs.scale_x);
    r.y = lerp_pos(v.ay, v.by, f, active_regs.scale_y);
    r.z = lerp_pos(v.az, v.bz, f, active_regs.scale_z);
    ia = (v.na >= NRM_COUNT) ? NRM_COUNT - 1 : v.na;
    ib = (v.nb >= NRM_COUNT) ? NRM_COUNT - 1 : v.nb;
    for (int k = 0; k < 3; k++) begin
      na = UNIT_NORMALS[ia][k];
      nb = UNIT_NORMALS[ib][k];
      n = round_q(na * 65536 + f * (nb - na), 16);
      nrm[k] = n[15:0];
    end
    r.nx = nrm[0];
    r.ny = nrm[1];
    r.nz = nrm[2];
    acc = longint'(active_regs.u_off) * 256 + longint'(v.s) * longint'(active_regs.u_gain);
    n = clip(round_q(acc, 8), -524288, 524287);
    r.s = n[19:0];
    // V is flipped: 1.0 minus the mapped coordinate
    acc = (65536 - longint'(active_regs.v_off)) * 256
        - longint'(v.t) * longint'(active_regs.v_gain);
    n = clip(round_q(acc, 8), -524288, 524287);
    r.t = n[19:0];
    r.last = v.last;
    return r;
  endfunction

  function automatic void check_field(string name, logic [23:0] got, logic [23:0] want);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch, expected %h got %h", $time, name, want, got);
    end
  endfunction

  // result checking, request capture and register shadowing, all on the same edge
  always @(posedge clk_i) begin
    result_t want;
    vertex_t seen;
    if (rst_ni) begin
      if (done_o) begin
        if (predicted_vertices.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("%0t: result with no request pending", $time);
        end else begin
          want = predicted_vertices.pop_front();
          check_field("out_x", out_x_o, want.x);
          check_field("out_y", out_y_o, want.y);
          check_field("out_z", out_z_o, want.z);
          check_field("normal_x", normal_x_o, want.nx);
          check_field("normal_y", normal_y_o, want.ny);
          check_field("normal_z", normal_z_o, want.nz);
          check_field("out_s", out_s_o, want.s);
          check_field("out_t", out_t_o, want.t);
          check_field("last_out", last_out_o, want.last);
        end
      end
      if (start && !busy) begin
        seen.ax = pos_a_x_i;
        seen.ay = pos_a_y_i;
        seen.az = pos_a_z_i;
        seen.bx = pos_b_x_i;
        seen.by = pos_b_y_i;
        seen.bz = pos_b_z_i;
        seen.na = normal_a_index_i;
        seen.nb = normal_b_index_i;
        seen.s = tex_s_i;
        seen.t = tex_t_i;
        seen.blend = blend_i;
        seen.last = last_vertex_i;
        predicted_vertices = {predicted_vertices, predict_vertex(seen)};
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SCALE_X:     active_regs.scale_x = cfg_wdata_i[15:0];
          CFG_SCALE_OUT_Y: active_regs.scale_y = cfg_wdata_i[15:0];
          CFG_SCALE_OUT_Z: active_regs.scale_z = cfg_wdata_i[15:0];
          CFG_U_OFFSET:    active_regs.u_off = cfg_wdata_i;
          CFG_V_OFFSET:    active_regs.v_off = cfg_wdata_i;
          CFG_U_GAIN:      active_regs.u_gain = cfg_wdata_i[15:0];
          CFG_V_GAIN:      active_regs.v_gain = cfg_wdata_i[15:0];
          default: ;
        endcase
      end
      if (done_o || (start && !busy) || cfg_we_i) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("tb NOT OK");
    $finish;
  end

  task automatic send_vertex(vertex_t v);
    int gap;
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pos_a_x_i <= v.ax;
    pos_a_y_i <= v.ay;
    pos_a_z_i <= v.az;
    pos_b_x_i <= v.bx;
    pos_b_y_i <= v.by;
    pos_b_z_i <= v.bz;
    normal_a_index_i <= v.na;
    normal_b_index_i <= v.nb;
    tex_s_i <= v.s;
    tex_t_i <= v.t;
    blend_i <= v.blend;
    last_vertex_i <= v.last;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk_i); while (predicted_vertices.size() != 0);
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  // bit 16 on the narrow registers gets random junk; the unused index is poked too
  task automatic write_regs(regs_t r);
    wait_idle();
    put_reg(CFG_SCALE_X, {1'($urandom), r.scale_x});
    put_reg(CFG_SCALE_OUT_Y, {1'($urandom), r.scale_y});
    put_reg(CFG_SCALE_OUT_Z, {1'($urandom), r.scale_z});
    put_reg(CFG_U_OFFSET, r.u_off);
    put_reg(CFG_V_OFFSET, r.v_off);
    put_reg(CFG_U_GAIN, {1'($urandom), r.u_gain});
    put_reg(CFG_V_GAIN, {1'($urandom), r.v_gain});
    put_reg(CFG_UNUSED, 17'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [23:0] random_pos();
    case ($urandom_range(0, 7))
      0:       return 24'h7FFFFF;
      1:       return 24'h800000;
      2, 3:    return 24'($urandom_range(0, 8191) - 4096);
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [16:0] random_unit();
    if ($urandom_range(0, 7) == 0) return 17'($urandom_range(0, 131071));
    return 17'($urandom_range(0, 65536));
  endfunction

  function automatic logic [15:0] random_gain();
    case ($urandom_range(0, 5))
      0:       return 16'd256;
      1:       return 16'hFFFF;
      2:       return 16'd0;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic vertex_t random_vertex();
    vertex_t v;
    v.ax = random_pos();
    v.ay = random_pos();
    v.az = random_pos();
    v.bx = random_pos();
    v.by = random_pos();
    v.bz = random_pos();
    v.na = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(162, 255)) : 8'($urandom_range(0, 161));
    v.nb = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(162, 255)) : 8'($urandom_range(0, 161));
    v.s = random_unit();
    v.t = random_unit();
    case ($urandom_range(0, 7))
      0:       v.blend = 17'd0;
      1:       v.blend = 17'd65536;
      2:       v.blend = 17'($urandom_range(65537, 131071));
      default: v.blend = 17'($urandom_range(0, 65536));
    endcase
    v.last = ($urandom_range(0, 15) == 0);
    return v;
  endfunction

  function automatic regs_t random_regs();
    regs_t r;
    r.scale_x = random_gain();
    r.scale_y = random_gain();
    r.scale_z = random_gain();
    r.u_off = random_unit();
    r.v_off = random_unit();
    r.u_gain = random_gain();
    r.v_gain = random_gain();
    return r;
  endfunction

  task automatic test_reset_defaults();
    vertex_t v;
    v = '{default: '0};
    send_vertex(v);
    v.ax = 24'h7FFFFF; v.ay = 24'h7FFFFF; v.az = 24'h7FFFFF;
    v.bx = 24'h800000; v.by = 24'h800000; v.bz = 24'h800000;
    v.nb = 8'd161;
    send_vertex(v);
    v.blend = 17'd65536;
    send_vertex(v);
    v.blend = 17'h1FFFF;   // above one, taken as one
    send_vertex(v);
    v.blend = 17'd32768; v.na = 8'd161; v.nb = 8'd162;
    send_vertex(v);
    v.na = 8'hFF; v.nb = 8'd0; v.s = 17'd65536; v.t = 17'd65536;
    send_vertex(v);
    v.s = 17'h1FFFF; v.t = 17'h1FFFF; v.last = 1'b1;
    send_vertex(v);
    v.ax = 24'h800000; v.ay = 24'h800000; v.az = 24'h800000;
    v.bx = 24'h7FFFFF; v.by = 24'h7FFFFF; v.bz = 24'h7FFFFF;
    v.blend = 17'd1; v.last = 1'b0;
    send_vertex(v);
  endtask

  task automatic test_saturation();
    vertex_t v;
    write_regs('{16'hFFFF, 16'hFFFF, 16'hFFFF, 17'h1FFFF, 17'h1FFFF, 16'hFFFF, 16'hFFFF});
    v = '{default: '0};
    v.ax = 24'h7FFFFF; v.ay = 24'h7FFFFF; v.az = 24'h7FFFFF;
    v.bx = 24'h800000; v.by = 24'h800000; v.bz = 24'h800000;
    send_vertex(v);
    v.blend = 17'd65536; v.s = 17'h1FFFF; v.t = 17'h1FFFF;
    send_vertex(v);
    v.blend = 17'd32768; v.s = 17'd65536; v.t = 17'd1;
    send_vertex(v);
    send_vertex(random_vertex());
  endtask

  task automatic test_zero_gains();
    write_regs('{16'd0, 16'd0, 16'd0, 17'd0, 17'd0, 16'd0, 16'd0});
    send_vertex(random_vertex());
    send_vertex(random_vertex());
  endtask

  task automatic test_random_vertices();
    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 7) allow_gaps = 1'b0;
      write_regs((phase == 0) ? REGS_RESET : random_regs());
      repeat (250) send_vertex(random_vertex());
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_saturation();
    test_zero_gains();
    test_random_vertices();
    wait_idle();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== keyframe_vertex_interpolator.f =====
design/kvi_pkg.sv
design/kvi_nrm_rom.sv
design/kvi_nrm_blend.sv
design/kvi_pos_lane.sv
design/keyframe_vertex_interpolator.sv
dv/tb.sv
